@@ hdl/h264rs_pkg.sv @@
// ----------------------------------------------------------------------------
// h264rs_pkg: shared types and constants for the H.264 RTP slice classifier
// Kind codes, NAL/FU header codes, result record and queue status types.
// ----------------------------------------------------------------------------
package h264rs_pkg;

  // leading payload bytes that the Exp-Golomb window may use
  localparam int HEADER_BYTES = 8;
  localparam int WIN_BYTES    = (HEADER_BYTES > 8) ? 8 : HEADER_BYTES;

  localparam int BYTES_W = 24;
  localparam int GAP_W   = 16;
  localparam int TS_W    = 32;
  localparam int SIZE_W  = 16;

  localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_P       = 2'd0,
    KIND_I       = 2'd1,
    KIND_UNKNOWN = 2'd2
  } slice_kind_t;

  // NAL unit types of interest
  localparam logic [4:0] NAL_NON_IDR = 5'd1;
  localparam logic [4:0] NAL_IDR     = 5'd5;
  localparam logic [4:0] NAL_FU_A    = 5'd28;
  localparam logic [4:0] NAL_FU_B    = 5'd29;

  // FU header flag positions
  localparam int FU_START_BIT = 7;
  localparam int FU_END_BIT   = 6;

  // header bytes consumed ahead of slice data
  localparam logic [1:0] OFF_ONE = 2'd1;
  localparam logic [1:0] OFF_TWO = 2'd2;

  typedef struct packed {
    slice_kind_t        kind;
    logic [BYTES_W-1:0] bytes;
    logic [GAP_W-1:0]   gap;
    logic [TS_W-1:0]    stamp;
    logic               last;
  } slice_rec_t;

  typedef struct packed {
    logic       room2;   // at least two free entries
    logic [2:0] level;   // entries held
  } fifo_stat_t;

endpackage

@@ hdl/h264rs_classify.sv @@
// ----------------------------------------------------------------------------
// h264rs_classify: slice type from the slice header window
// Decodes the first macroblock address and the slice type code (Exp-Golomb)
// inside the window.
// ----------------------------------------------------------------------------
module h264rs_classify (
  input  logic [63:0]                    head_bytes,
  input  logic [1:0]                     off,
  input  logic [h264rs_pkg::SIZE_W-1:0]  size,
  output h264rs_pkg::slice_kind_t        kind
);

  logic [3:0]  win_rem;
  logic [3:0]  avail_bytes;
  logic [6:0]  avail_bits;
  logic [63:0] w;
  logic [5:0]  z1;
  logic        found;
  logic [7:0]  p1;
  logic [63:0] w_sh;
  logic [7:0]  x;
  logic [3:0]  len2;
  h264rs_pkg::slice_kind_t code_kind;
  logic [8:0]  code_end;

  assign win_rem     = 4'(h264rs_pkg::WIN_BYTES) - {2'b00, off};
  assign avail_bytes = (size < {12'd0, win_rem}) ? size[3:0] : win_rem;
  assign avail_bits  = {avail_bytes, 3'b000};

  assign w = head_bytes << {off, 3'b000};

  // leading zero count of the first code
  always_comb begin
    z1    = '0;
    found = 1'b0;
    for (int i = 0; i < 64; i++) begin
      if (w[i]) begin
        z1    = 6'(63 - i);
        found = 1'b1;
      end
    end
  end

  assign p1   = {1'b0, z1, 1'b1};
  assign w_sh = w << p1;
  assign x    = w_sh[63:56];

  // only slice type codes 0, 2, 5, 7 matter; longer codes are unknown
  always_comb begin
    len2      = 4'd0;
    code_kind = h264rs_pkg::KIND_UNKNOWN;
    if (x[7]) begin
      len2      = 4'd1;
      code_kind = h264rs_pkg::KIND_P;
    end else if (x[6]) begin
      len2      = 4'd3;
      code_kind = x[5] ? h264rs_pkg::KIND_I : h264rs_pkg::KIND_UNKNOWN;
    end else if (x[5]) begin
      len2      = 4'd5;
      code_kind = (x[4:3] == 2'd2) ? h264rs_pkg::KIND_P : h264rs_pkg::KIND_UNKNOWN;
    end else if (x[4]) begin
      len2      = 4'd7;
      code_kind = (x[3:1] == 3'd0) ? h264rs_pkg::KIND_I : h264rs_pkg::KIND_UNKNOWN;
    end
  end

  assign code_end = {1'b0, p1} + {5'd0, len2};

  assign kind = (found && len2 != 4'd0 && code_end <= {2'b00, avail_bits})
              ? code_kind : h264rs_pkg::KIND_UNKNOWN;

endmodule

@@ hdl/h264rs_rec_fifo.sv @@
// ----------------------------------------------------------------------------
// h264rs_rec_fifo: four-entry result queue
// Takes up to two records per cycle, hands out one.
// ----------------------------------------------------------------------------
module h264rs_rec_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [1:0]             n_push,
  input  h264rs_pkg::slice_rec_t rec0,
  input  h264rs_pkg::slice_rec_t rec1,
  input  logic                   pop,
  output h264rs_pkg::slice_rec_t head,
  output logic                   not_empty,
  output h264rs_pkg::fifo_stat_t stat
);

  h264rs_pkg::slice_rec_t mem [4];
  logic [1:0] wr_r, wr_nxt;
  logic [1:0] rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign not_empty = (cnt_r != 3'd0);
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_r];

  assign stat.room2 = (cnt_r <= 3'd2);
  assign stat.level = cnt_r;

  assign wr_nxt  = wr_r + n_push;
  assign rd_nxt  = rd_r + {1'b0, do_pop};
  assign cnt_nxt = cnt_r + {1'b0, n_push} - {2'b00, do_pop};

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_r] <= rec0;
    end
    if (n_push == 2'd2) begin
      mem[wr_r + 2'd1] <= rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ hdl/h264_rtp_slice_classifier.sv @@
// ----------------------------------------------------------------------------
// h264_rtp_slice_classifier: H.264 RTP packet to slice record classifier
// Decodes NAL/FU headers, classifies slices, collects FU fragments by stamp.
// ----------------------------------------------------------------------------
// An accepted item is held in the input register; its records then pass through the result queue.
// Throughput: one item per cycle while the result queue has room for two records;
//   an item that causes two results hands them out in turn through the single output port of the queue.
// Input is stalled only while the four-entry result queue lacks two free slots.
// Reset (rst_n low, synchronous) empties the input register and the queue and
//   drops any pending fragment record.
module h264_rtp_slice_classifier (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_fu_header_first,
  input  logic [63:0] in_head_bytes,
  input  logic [15:0] in_payload_size,
  input  logic [15:0] in_seq_gap,
  input  logic [31:0] in_timestamp,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_slice_kind,
  output logic [23:0] out_slice_bytes,
  output logic [15:0] out_missing_packets,
  output logic [31:0] out_slice_time,
  output logic        out_last
);

  // -------------------------------------------------------------------------
  // Input register
  // -------------------------------------------------------------------------
  logic        in_vld_r, in_vld_nxt;
  logic        fu_r;
  logic [63:0] head_r;
  logic [15:0] psize_r;
  logic [15:0] gap_r;
  logic [31:0] ts_r;

  logic in_take;
  logic proc;

  h264rs_pkg::fifo_stat_t fstat;

  assign proc     = in_vld_r && fstat.room2;
  assign in_stall = in_vld_r && !fstat.room2;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (proc) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      fu_r    <= in_fu_header_first;
      head_r  <= in_head_bytes;
      psize_r <= in_payload_size;
      gap_r   <= in_seq_gap;
      ts_r    <= in_timestamp;
    end
  end

  // -------------------------------------------------------------------------
  // Header decode
  // -------------------------------------------------------------------------
  logic [7:0]  b0, b1, hdr;
  logic [4:0]  t0, ht;
  logic        is_single;   // NAL type 1/5 carried whole
  logic        is_fu_nal;   // FU-A/FU-B indicator in byte zero
  logic        fu_ok;       // FU fragment carrying a slice type
  logic [1:0]  off;
  logic [15:0] size;
  logic        hdr_start, hdr_end;
  h264rs_pkg::slice_kind_t kind;

  assign b0 = head_r[63:56];
  assign b1 = head_r[55:48];
  assign t0 = b0[4:0];

  assign is_single = !fu_r && (t0 == h264rs_pkg::NAL_NON_IDR || t0 == h264rs_pkg::NAL_IDR);
  assign is_fu_nal = !fu_r && (t0 == h264rs_pkg::NAL_FU_A || t0 == h264rs_pkg::NAL_FU_B);

  assign hdr = fu_r ? b0 : b1;
  assign ht  = hdr[4:0];
  // nested FU headers fall out here: their own type is 28/29
  assign fu_ok = (fu_r || is_fu_nal) &&
                 (ht == h264rs_pkg::NAL_NON_IDR || ht == h264rs_pkg::NAL_IDR);

  assign off       = (fu_r || is_single) ? h264rs_pkg::OFF_ONE : h264rs_pkg::OFF_TWO;
  assign size      = (psize_r > {14'd0, off}) ? (psize_r - {14'd0, off}) : 16'd0;
  assign hdr_start = hdr[h264rs_pkg::FU_START_BIT];
  assign hdr_end   = hdr[h264rs_pkg::FU_END_BIT];

  // one classifier serves single slices and FU start fragments
  h264rs_classify u_classify (
    .head_bytes (head_r),
    .off        (off),
    .size       (size),
    .kind       (kind)
  );

  // -------------------------------------------------------------------------
  // Pending fragment record
  // -------------------------------------------------------------------------
  logic                    pv_r, pv_nxt;
  h264rs_pkg::slice_kind_t pk_r, pk_nxt;
  logic [23:0]             pb_r, pb_nxt;
  logic [15:0]             pg_r, pg_nxt;
  logic [31:0]             pt_r, pt_nxt;

  logic [24:0] sum;
  logic [23:0] sum_sat;
  logic [15:0] gap_sum;
  logic        same_ts;

  assign sum     = {1'b0, pb_r} + {9'd0, size};
  assign sum_sat = sum[24] ? h264rs_pkg::BYTES_MAX : sum[23:0];
  assign gap_sum = pg_r + gap_r;
  assign same_ts = (ts_r == pt_r);

  logic [1:0]             n_push;
  h264rs_pkg::slice_rec_t rec0, rec1;

  always_comb begin
    pv_nxt = pv_r;
    pk_nxt = pk_r;
    pb_nxt = pb_r;
    pg_nxt = pg_r;
    pt_nxt = pt_r;
    n_push = 2'd0;
    // default record: unknown kind, this packet's figures, final
    rec0 = '{kind: h264rs_pkg::KIND_UNKNOWN, bytes: {8'd0, size}, gap: gap_r,
             stamp: ts_r, last: 1'b1};
    rec1 = rec0;
    if (proc) begin
      if (is_single) begin
        // single slice reported at once; pending record is dropped
        rec0.kind = kind;
        n_push    = 2'd1;
        pv_nxt    = 1'b0;
      end else if (fu_ok) begin
        if (hdr_start) begin
          pv_nxt = 1'b1;
          pk_nxt = kind;
          pb_nxt = {8'd0, size};
          pg_nxt = gap_r;
          pt_nxt = ts_r;
        end else if (pv_r && same_ts) begin
          pb_nxt = sum_sat;
          pg_nxt = gap_sum;
          if (hdr_end) begin
            rec0   = '{kind: pk_r, bytes: sum_sat, gap: gap_sum, stamp: pt_r,
                       last: 1'b1};
            n_push = 2'd1;
            pv_nxt = 1'b0;
          end
        end else if (pv_r) begin
          // stamp mismatch: flush pending with one extra lost packet, then
          // report this fragment as unknown
          rec0   = '{kind: pk_r, bytes: pb_r, gap: pg_r + 16'd1, stamp: pt_r,
                     last: 1'b0};
          n_push = 2'd2;
          pv_nxt = 1'b0;
        end else begin
          // orphan fragment
          n_push = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pk_r <= pk_nxt;
    pb_r <= pb_nxt;
    pg_r <= pg_nxt;
    pt_r <= pt_nxt;
  end

  // -------------------------------------------------------------------------
  // Result queue
  // -------------------------------------------------------------------------
  h264rs_pkg::slice_rec_t head_rec;

  h264rs_rec_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .n_push    (n_push),
    .rec0      (rec0),
    .rec1      (rec1),
    .pop       (!out_stall),
    .head      (head_rec),
    .not_empty (out_valid),
    .stat      (fstat)
  );

  assign out_slice_kind      = head_rec.kind;
  assign out_slice_bytes     = head_rec.bytes;
  assign out_missing_packets = head_rec.gap;
  assign out_slice_time      = head_rec.stamp;
  assign out_last            = head_rec.last;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    fstat.level <= 3'd4)
    else $error("result queue over capacity");

  a_nonfinal_paired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> fstat.level >= 3'd2)
    else $error("non-final record without its final partner");

  a_single_clears: assert property (@(posedge clk) disable iff (!rst_n)
    proc && is_single |=> !pv_r)
    else $error("pending record survived a single slice");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    n_push != 2'd0 |-> fstat.room2 && in_vld_r)
    else $error("push without a processed item or room");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: H.264 RTP slice classifier
// Sends RTP packet headers and checks each slice record against a predictor.
// ----------------------------------------------------------------------------
module testbench;
  import h264rs_pkg::*;

  // slice type codes carried in the slice header
  localparam logic [31:0] ST_P     = 32'd0;
  localparam logic [31:0] ST_I     = 32'd2;
  localparam logic [31:0] ST_SP    = 32'd3;
  localparam logic [31:0] ST_P_ALL = 32'd5;
  localparam logic [31:0] ST_I_ALL = 32'd7;

  localparam int MAX_REPORTS = 10;
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int STALL_LIMIT = 2000;  // cycles with no item moving on either side

  // one RTP packet as seen at the input port
  typedef struct packed {
    logic        fu_first;
    logic [63:0] head;
    logic [15:0] size;
    logic [15:0] gap;
    logic [31:0] stamp;
  } packet_t;

  logic        clk;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_fu_header_first = 1'b0;
  logic [63:0] in_head_bytes = '0;
  logic [15:0] in_payload_size = '0;
  logic [15:0] in_seq_gap = '0;
  logic [31:0] in_timestamp = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_slice_kind;
  logic [23:0] out_slice_bytes;
  logic [15:0] out_missing_packets;
  logic [31:0] out_slice_time;
  logic        out_last;

  h264_rtp_slice_classifier DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_fu_header_first  (in_fu_header_first),
    .in_head_bytes       (in_head_bytes),
    .in_payload_size     (in_payload_size),
    .in_seq_gap          (in_seq_gap),
    .in_timestamp        (in_timestamp),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_slice_kind      (out_slice_kind),
    .out_slice_bytes     (out_slice_bytes),
    .out_missing_packets (out_missing_packets),
    .out_slice_time      (out_slice_time),
    .out_last            (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // slice records still owed by the block, oldest first
  slice_rec_t due_slices[$];
  int errors = 0;

  // idle rates in percent, changed only between phases
  int send_idle_pct = 27;
  int recv_stall_pct = 74;

  // hold-off requests: the test bumps hold_gen, the receiver does the counting
  int hold_gen = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int idle_cycles = 0;

  // fragment collector mirror
  logic        frag_valid = 1'b0;
  slice_kind_t frag_kind = KIND_P;
  logic [23:0] frag_bytes = '0;
  logic [15:0] frag_gap = '0;
  logic [31:0] frag_time = '0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Reads the first macroblock address and the slice type as ue(v) codes from
  // the slice data. The window is the header bytes left after the NAL/FU
  // header, cut down to the slice size; a code running past it makes the
  // slice unknown.
  function automatic slice_kind_t classify_slice(input logic [63:0] head, input int off,
                                                 input int sz);
    logic [63:0] w;
    logic [63:0] code;
    int avail, pos, zeros, n, i;
    avail = (WIN_BYTES > off) ? WIN_BYTES - off : 0;
    if (sz < avail) avail = sz;
    avail = avail * 8;
    w = head << (off * 8);
    pos = 0;
    code = '0;
    for (n = 0; n < 2; n++) begin
      zeros = 0;
      while (pos < avail && !w[63 - pos]) begin
        pos++;
        zeros++;
      end
      if (pos >= avail) return KIND_UNKNOWN;
      pos++;
      if (pos + zeros > avail) return KIND_UNKNOWN;
      code = '0;
      for (i = 0; i < zeros; i++) begin
        code = {code[62:0], w[63 - pos]};
        pos++;
      end
      code = ((64'd1 << zeros) - 64'd1) + code;
    end
    // code now holds the slice type
    if (code == ST_P || code == ST_P_ALL) return KIND_P;
    if (code == ST_I || code == ST_I_ALL) return KIND_I;
    return KIND_UNKNOWN;
  endfunction

  function automatic void expect_slice(input slice_kind_t k, input logic [23:0] b,
                                       input logic [15:0] g, input logic [31:0] t,
                                       input logic l);
    slice_rec_t r;
    r.kind = k;
    r.bytes = b;
    r.gap = g;
    r.stamp = t;
    r.last = l;
    due_slices.push_back(r);
  endfunction

  // Updates the fragment mirror for one accepted packet and queues its records.
  function automatic void predict_slices(input packet_t p);
    logic [7:0] fuh;
    logic [4:0] nal;
    logic [24:0] sum;
    int off, sz;
    nal = p.head[60:56];
    if (!p.fu_first) begin
      if (nal == NAL_NON_IDR || nal == NAL_IDR) begin
        // single NAL slice: reported at once, any open fragment is dropped
        sz = (p.size > 1) ? p.size - 1 : 0;
        frag_valid = 1'b0;
        expect_slice(classify_slice(p.head, 1, sz), sz, p.gap, p.stamp, 1'b1);
        return;
      end
      if (nal != NAL_FU_A && nal != NAL_FU_B) return;
      fuh = p.head[55:48];
      off = 2;
    end else begin
      fuh = p.head[63:56];
      off = 1;
    end
    // FU payload must carry a slice; nested FU types are dropped too
    if (fuh[4:0] != NAL_NON_IDR && fuh[4:0] != NAL_IDR) return;
    sz = (p.size > off) ? p.size - off : 0;

    if (fuh[FU_START_BIT]) begin
      frag_kind = classify_slice(p.head, off, sz);
      frag_bytes = sz;
      frag_gap = p.gap;
      frag_time = p.stamp;
      frag_valid = 1'b1;
      return;
    end

    if (frag_valid) begin
      if (p.stamp == frag_time) begin
        sum = frag_bytes + sz;
        frag_bytes = (sum > BYTES_MAX) ? BYTES_MAX : sum[23:0];
        frag_gap = frag_gap + p.gap;
        if (fuh[FU_END_BIT]) begin
          expect_slice(frag_kind, frag_bytes, frag_gap, frag_time, 1'b1);
          frag_valid = 1'b0;
        end
        return;
      end
      // new stamp before the end fragment: flush, counting the lost end
      frag_gap = frag_gap + 16'd1;
      expect_slice(frag_kind, frag_bytes, frag_gap, frag_time, 1'b0);
      frag_valid = 1'b0;
      expect_slice(KIND_UNKNOWN, sz, p.gap, p.stamp, 1'b1);
      return;
    end

    // middle or end with no start seen
    expect_slice(KIND_UNKNOWN, sz, p.gap, p.stamp, 1'b1);
  endfunction

  // --------------------------------------------------------------------------
  // Packet builders
  // --------------------------------------------------------------------------

  // ue(v) codes for the first macroblock address and the slice type, MSB
  // first, random tail
  function automatic logic [63:0] golomb_pair(input logic [31:0] first_mb,
                                              input logic [31:0] st);
    logic [63:0] bits;
    logic [31:0] v;
    int len, n, k, i;
    bits = {$urandom, $urandom};
    len = 0;
    for (k = 0; k < 2; k++) begin
      v = (k == 0) ? first_mb + 32'd1 : st + 32'd1;
      n = 0;
      while (n < 32 && (v >> n) != 0) n++;
      for (i = 0; i < n - 1; i++) bits[63 - len - i] = 1'b0;
      len += n - 1;
      for (i = n - 1; i >= 0; i--) begin
        bits[63 - len] = v[i];
        len++;
      end
    end
    return bits;
  endfunction

  function automatic logic [7:0] nal_byte(input logic [4:0] t);
    logic [2:0] top;
    top = $urandom_range(7);
    return {top, t};
  endfunction

  function automatic logic [7:0] fu_byte(input logic s, input logic e, input logic [4:0] t);
    logic rsv;
    rsv = $urandom_range(1);
    return {s, e, rsv, t};
  endfunction

  // header bytes go in front, slice data fills the rest of the window
  function automatic packet_t make_packet(input logic fu_first, input logic [7:0] h0,
                                          input logic [7:0] h1, input int hdr_len,
                                          input logic [63:0] data, input logic [15:0] size,
                                          input logic [15:0] gap, input logic [31:0] stamp);
    packet_t p;
    p.fu_first = fu_first;
    p.head = (hdr_len == 2) ? {h0, h1, data[63:16]} : {h0, data[63:8]};
    p.size = size;
    p.gap = gap;
    p.stamp = stamp;
    return p;
  endfunction

  function automatic logic [15:0] rand_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return $urandom_range(3);
    if (roll < 20) return $urandom_range(65535);
    if (roll < 23) return 16'hFFFF;
    return $urandom_range(1500, 20);
  endfunction

  function automatic logic [15:0] rand_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 16'd0;
    if (roll < 85) return $urandom_range(3, 1);
    return $urandom_range(65535);
  endfunction

  // mostly well-formed slice headers, sometimes codes too long or plain noise
  function automatic logic [63:0] slice_data();
    int roll;
    logic [31:0] first_mb;
    roll = $urandom_range(99);
    if (roll < 8) return {$urandom, $urandom};
    if (roll < 85) first_mb = $urandom_range(200);
    else if (roll < 95) first_mb = $urandom_range(65535);
    else first_mb = (32'd1 << 28) | $urandom_range(65535);
    return golomb_pair(first_mb, $urandom_range(9));
  endfunction

  function automatic logic [4:0] slice_nal();
    return $urandom_range(1) ? NAL_IDR : NAL_NON_IDR;
  endfunction

  function automatic packet_t single_slice(input logic [31:0] stamp);
    return make_packet(1'b0, nal_byte(slice_nal()), 8'h00, 1, slice_data(), rand_size(),
                       rand_gap(), stamp);
  endfunction

  // one fragment, FU-A/FU-B behind a NAL byte or with the FU header first
  function automatic packet_t fragment(input logic s, input logic e,
                                       input logic [31:0] stamp);
    logic [7:0] fuh;
    fuh = fu_byte(s, e, slice_nal());
    if ($urandom_range(3) == 0)
      return make_packet(1'b1, fuh, 8'h00, 1, slice_data(), rand_size(), rand_gap(), stamp);
    return make_packet(1'b0, nal_byte($urandom_range(1) ? NAL_FU_B : NAL_FU_A), fuh, 2,
                       slice_data(), rand_size(), rand_gap(), stamp);
  endfunction

  // --------------------------------------------------------------------------
  // Sender, receiver, checker, watchdog
  // --------------------------------------------------------------------------

  // Offers one packet from a falling edge and holds it until taken.
  task automatic send_packet(input packet_t p);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_fu_header_first <= p.fu_first;
    in_head_bytes <= p.head;
    in_payload_size <= p.size;
    in_seq_gap <= p.gap;
    in_timestamp <= p.stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_slices(p);
  endtask

  // sender stops and waits for every owed record
  task automatic wait_for_slices();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_slices.size() != 0) @(posedge clk);
  endtask

  // receiver stall, random or a counted hold-off
  always @(negedge clk) begin
    if (hold_seen != hold_gen) begin
      hold_seen = hold_gen;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_slices
    slice_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_slices.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected slice record: kind %0d bytes %0d gap %0d ts %h last %0d",
                   out_slice_kind, out_slice_bytes, out_missing_packets, out_slice_time,
                   out_last);
      end else begin
        want = due_slices.pop_front();
        if (out_slice_kind !== want.kind || out_slice_bytes !== want.bytes ||
            out_missing_packets !== want.gap || out_slice_time !== want.stamp ||
            out_last !== want.last) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("slice mismatch: exp kind %0d bytes %0d gap %0d ts %h last %0d",
                     want.kind, want.bytes, want.gap, want.stamp, want.last);
            $display("                got kind %0d bytes %0d gap %0d ts %h last %0d",
                     out_slice_kind, out_slice_bytes, out_missing_packets, out_slice_time,
                     out_last);
          end
        end
      end
    end
  end

  // ends a hung run: counts cycles in which no item moves on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Header decode, slice types, window limits, fragment collection and flushes.
  task automatic test_header_cases();
    // single slices: P, I with size/gap/stamp at max, the other slice types
    send_packet(make_packet(1'b0, nal_byte(NAL_NON_IDR), 8'h00, 1,
                            golomb_pair(0, ST_P), 16'd100, 16'd0, 32'h0000_1000));
    send_packet(make_packet(1'b0, 8'hE5, 8'h00, 1, golomb_pair(5, ST_I_ALL),
                            16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_packet(make_packet(1'b0, nal_byte(NAL_NON_IDR), 8'h00, 1,
                            golomb_pair(1, ST_P_ALL), 16'd60, 16'd1, 32'd0));
    send_packet(make_packet(1'b0, nal_byte(NAL_IDR), 8'h00, 1,
                            golomb_pair(2, ST_I), 16'd61, 16'd2, 32'd1));
    send_packet(make_packet(1'b0, nal_byte(NAL_NON_IDR), 8'h00, 1,
                            golomb_pair(0, ST_SP), 16'd62, 16'd0, 32'd2));
    // tiny payloads: empty window, then a one-byte window that just fits
    send_packet(make_packet(1'b0, nal_byte(NAL_NON_IDR), 8'h00, 1,
                            golomb_pair(0, ST_P), 16'd0, 16'd0, 32'd3));
    send_packet(make_packet(1'b0, nal_byte(NAL_NON_IDR), 8'h00, 1,
                            golomb_pair(0, ST_P), 16'd2, 16'd0, 32'd4));
    // codes running off the window: all-zero data, huge first_mb
    send_packet(make_packet(1'b0, nal_byte(NAL_IDR), 8'h00, 1, 64'd0, 16'd900, 16'd0,
                            32'd5));
    send_packet(make_packet(1'b0, nal_byte(NAL_NON_IDR), 8'h00, 1,
                            golomb_pair(32'd1 << 28, ST_P), 16'd900, 16'd0, 32'd6));
    // all-ones data decodes as first_mb 0, P
    send_packet(make_packet(1'b0, nal_byte(NAL_NON_IDR), 8'h00, 1, '1, 16'd70, 16'd0,
                            32'd7));
    // NAL types that are not slices or FU: ignored
    send_packet(make_packet(1'b0, 8'h00, 8'h85, 2, '1, 16'd50, 16'd0, 32'd8));
    send_packet(make_packet(1'b0, 8'hFF, 8'h85, 2, '1, 16'd50, 16'd0, 32'd8));
    // FU-A start, middle, end collected into one I record
    send_packet(make_packet(1'b0, nal_byte(NAL_FU_A), fu_byte(1'b1, 1'b0, NAL_NON_IDR), 2,
                            golomb_pair(3, ST_I), 16'd500, 16'd1, 32'hA000_0000));
    send_packet(make_packet(1'b0, nal_byte(NAL_FU_A), fu_byte(1'b0, 1'b0, NAL_NON_IDR), 2,
                            {$urandom, $urandom}, 16'd1400, 16'd2, 32'hA000_0000));
    send_packet(make_packet(1'b0, nal_byte(NAL_FU_A), fu_byte(1'b0, 1'b1, NAL_NON_IDR), 2,
                            {$urandom, $urandom}, 16'd1, 16'd0, 32'hA000_0000));
    // FU header first, start and end both set (start wins), then the end
    send_packet(make_packet(1'b1, fu_byte(1'b1, 1'b1, NAL_IDR), 8'h00, 1,
                            golomb_pair(0, ST_I_ALL), 16'd300, 16'd0, 32'hB0));
    send_packet(make_packet(1'b1, fu_byte(1'b0, 1'b1, NAL_IDR), 8'h00, 1,
                            {$urandom, $urandom}, 16'd300, 16'd4, 32'hB0));
    // nested FU headers: ignored
    send_packet(make_packet(1'b0, nal_byte(NAL_FU_B), fu_byte(1'b1, 1'b0, NAL_FU_B), 2,
                            '1, 16'd80, 16'd0, 32'hC0));
    send_packet(make_packet(1'b1, fu_byte(1'b0, 1'b1, NAL_FU_A), 8'h00, 1, '1, 16'd80,
                            16'd0, 32'hC0));
    // orphan middle and end
    send_packet(make_packet(1'b1, fu_byte(1'b0, 1'b0, NAL_NON_IDR), 8'h00, 1, '1, 16'd90,
                            16'd3, 32'hD0));
    send_packet(make_packet(1'b0, nal_byte(NAL_FU_B), fu_byte(1'b0, 1'b1, NAL_IDR), 2, '1,
                            16'd1, 16'd5, 32'hD1));
    // stamp change mid-slice, gap at max so the flush wraps it to zero
    send_packet(make_packet(1'b0, nal_byte(NAL_FU_A), fu_byte(1'b1, 1'b0, NAL_IDR), 2,
                            golomb_pair(9, ST_P), 16'd300, 16'hFFFF, 32'hE0));
    send_packet(make_packet(1'b0, nal_byte(NAL_FU_A), fu_byte(1'b0, 1'b1, NAL_IDR), 2,
                            '1, 16'd40, 16'd7, 32'hE1));
    // single slice drops the open fragment, so its end is an orphan
    send_packet(make_packet(1'b1, fu_byte(1'b1, 1'b0, NAL_NON_IDR), 8'h00, 1,
                            golomb_pair(0, ST_P), 16'd200, 16'd0, 32'hF0));
    send_packet(make_packet(1'b0, nal_byte(NAL_IDR), 8'h00, 1,
                            golomb_pair(0, ST_I), 16'd20, 16'd0, 32'hF0));
    send_packet(make_packet(1'b1, fu_byte(1'b0, 1'b1, NAL_NON_IDR), 8'h00, 1, '1,
                            16'd20, 16'd0, 32'hF0));
    // payload shorter than its headers: size clamps to zero
    send_packet(make_packet(1'b0, nal_byte(NAL_FU_A), fu_byte(1'b1, 1'b0, NAL_IDR), 2,
                            golomb_pair(0, ST_P), 16'd1, 16'd0, 32'hF1));
    send_packet(make_packet(1'b0, nal_byte(NAL_FU_A), fu_byte(1'b0, 1'b1, NAL_IDR), 2,
                            '1, 16'd0, 16'd0, 32'hF1));
  endtask

  // Enough max-size fragments of one slice to push the byte sum past 24 bits.
  task automatic test_byte_saturation();
    logic [31:0] stamp;
    int i;
    stamp = $urandom;
    send_packet(make_packet(1'b1, fu_byte(1'b1, 1'b0, NAL_IDR), 8'h00, 1,
                            golomb_pair(0, ST_I_ALL), 16'hFFFF, rand_gap(), stamp));
    for (i = 0; i < 256; i++)
      send_packet(make_packet(1'b1, fu_byte(1'b0, 1'b0, NAL_IDR), 8'h00, 1,
                              {$urandom, $urandom}, 16'hFFFF, $urandom, stamp));
    send_packet(make_packet(1'b1, fu_byte(1'b0, 1'b1, NAL_IDR), 8'h00, 1,
                            {$urandom, $urandom}, 16'hFFFF, $urandom, stamp));
  endtask

  // Mostly whole slices, single or fragmented, with lost ends, stamp changes,
  // orphans and raw noise mixed in. Ignored noise does not use up the budget.
  task automatic test_random_traffic(input int target);
    logic [31:0] stamp;
    int budget, roll, n_mid, i;
    budget = target;
    while (budget > 0) begin
      roll = $urandom_range(99);
      stamp = $urandom;
      if (roll < 30) begin
        send_packet(single_slice(stamp));
        budget--;
      end else if (roll < 78) begin
        n_mid = $urandom_range(3);
        send_packet(fragment(1'b1, $urandom_range(1), stamp));
        for (i = 0; i < n_mid; i++) send_packet(fragment(1'b0, 1'b0, stamp));
        roll = $urandom_range(99);
        if (roll < 80)
          send_packet(fragment(1'b0, 1'b1, stamp));
        else if (roll < 92)
          send_packet(fragment(1'b0, $urandom_range(1), stamp + 1 + $urandom_range(1000)));
        // else the end is lost and the next slice takes over
        budget -= n_mid + 2;
      end else if (roll < 90) begin
        send_packet(fragment(1'b0, $urandom_range(1), stamp));
        budget--;
      end else begin
        send_packet(make_packet($urandom_range(1), $urandom, $urandom, 2,
                                {$urandom, $urandom}, rand_size(), rand_gap(), stamp));
      end
    end
  endtask

  // Receiver holds off while the sender keeps going, filling the result queue.
  task automatic test_receiver_holdoff();
    int i;
    send_idle_pct = 0;
    hold_gen++;
    for (i = 0; i < 60; i++) send_packet(single_slice($urandom));
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // sender idles 27%, receiver stalls 74%
    test_header_cases();
    wait_for_slices();
    test_byte_saturation();
    wait_for_slices();
    test_random_traffic(450);
    wait_for_slices();

    // roles swapped
    send_idle_pct = 74;
    recv_stall_pct = 27;
    test_random_traffic(450);
    wait_for_slices();

    test_receiver_holdoff();
    wait_for_slices();

    // back to back both ways
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_traffic(400);
    wait_for_slices();

    // room for any stray record to show up
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/h264rs_pkg.sv
hdl/h264rs_classify.sv
hdl/h264rs_rec_fifo.sv
hdl/h264_rtp_slice_classifier.sv
bench/testbench.sv
